/* design/assert_macros.svh */
// Assertion helpers used by the RTL file harmonic_product_spectrum_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// Types, constants and microcode table for the harmonic product spectrum unit.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int BINS_DEFAULT      = 4096;
  localparam int HARMONICS_DEFAULT = 5;

  localparam int INDEX_W = 12;
  localparam int MAG_W   = 16;
  localparam int VALUE_W = 64;
  localparam int ADDR_SPAN = 1 << INDEX_W;   // bins reachable by a write

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] bin_index;
    logic [MAG_W-1:0]   magnitude;
  } req_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_echo;
    logic [VALUE_W-1:0] hps_value;
    logic               saturated;
  } rsp_item_t;

  // microprogram addresses
  typedef enum logic [1:0] {
    STEP_WAIT  = 2'd0,
    STEP_PRIME = 2'd1,
    STEP_LOOP  = 2'd2,
    STEP_EMIT  = 2'd3
  } step_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_QUERY    = 2'd1,
    COND_LAST     = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_t;

  typedef struct packed {
    logic  take;      // input channel open
    logic  issue_rd;  // read spectrum at k, advance k
    logic  mul;       // fold read data into product
    logic  emit;      // load result register
    cond_t cond;
    step_t target;    // taken when cond holds
    step_t fall;      // taken otherwise
  } ctl_word_t;

  function automatic ctl_word_t ucode_rom(input step_t addr);
    ctl_word_t w;
    w = '0;
    unique case (addr)
      STEP_WAIT: begin
        w.take = 1'b1; w.cond = COND_QUERY;
        w.target = STEP_PRIME; w.fall = STEP_WAIT;
      end
      STEP_PRIME: begin
        w.issue_rd = 1'b1; w.cond = COND_ALWAYS;
        w.target = STEP_LOOP; w.fall = STEP_LOOP;
      end
      STEP_LOOP: begin
        w.issue_rd = 1'b1; w.mul = 1'b1; w.cond = COND_LAST;
        w.target = STEP_EMIT; w.fall = STEP_LOOP;
      end
      STEP_EMIT: begin
        w.emit = 1'b1; w.cond = COND_OUT_FREE;
        w.target = STEP_WAIT; w.fall = STEP_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* design/harmonic_product_spectrum_unit.sv */
// ----------------------------------------------------------------------------
// harmonic_product_spectrum_unit
// Spectrum store with harmonic product queries, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one transaction per item.
//   mode MODE_WRITE stores req.magnitude at req.bin_index and gives no result;
//   writes at or above BINS are dropped. Writes leave the sequencer in WAIT.
//   mode MODE_QUERY returns one rsp transaction: the product of bin j and
//   every in-range harmonic bin j*h, h = 2..HARMONICS, saturated to 64 bits
//   with the saturated flag set when the exact product overflows.
//   A query is accepted only in the WAIT step of the microprogram. It then
//   passes PRIME, one priming read of the spectrum RAM, then LOOP, one
//   factor per cycle (the single RAM read port and the 64x16 multiplier
//   share the loop, next read overlapping the current multiply), then EMIT,
//   which loads the result register. No new request is taken until the
//   sequencer is back in WAIT after EMIT.
//   The result register decouples the two sides: a new transaction is taken
//   while an earlier result still waits under rsp_stall; a second result
//   holds in the EMIT step until the register frees up.
//   Reset (rst, synchronous) returns the sequencer to WAIT and drops any
//   pending result; req_stall stays high while rst is. The spectrum RAM
//   is not cleared: read bins only after they were written.
// ----------------------------------------------------------------------------
module harmonic_product_spectrum_unit
  #(parameter int BINS      = hps_pkg::BINS_DEFAULT,
    parameter int HARMONICS = hps_pkg::HARMONICS_DEFAULT)
  (input  logic              clk,
   input  logic              rst,
   input  logic              req_valid,
   output logic              req_stall,
   input  hps_pkg::req_item_t req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hps_pkg::rsp_item_t rsp);

  import hps_pkg::*;

  `include "assert_macros.svh"

  // Only the first 4096 bins can ever be written; higher bins read as zero.
  localparam int MEM_DEPTH = (BINS < ADDR_SPAN) ? BINS : ADDR_SPAN;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int KW        = $clog2(ADDR_SPAN * (HARMONICS + 1));
  localparam int HW        = $clog2(HARMONICS + 1);
  localparam int CW        = 18;   // compare width, covers BINS up to 65536
  localparam logic [CW-1:0] BINS_C  = CW'(BINS);
  localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);
  localparam logic [HW-1:0] LAST_H  = HW'(HARMONICS);

  // Sequencer
  step_t     step, step_next;
  ctl_word_t ctl;
  logic      cond_true;

  // Datapath registers
  logic [INDEX_W-1:0] j;
  logic [KW-1:0]      k;
  logic [HW-1:0]      h;
  logic [VALUE_W-1:0] acc;
  logic               over;
  logic               zero;
  logic [MAG_W-1:0]   rd_data;
  logic               rd_in_range;   // bin of the read lies below BINS
  logic               rd_stored;     // bin of the read is held in the RAM

  logic [MAG_W-1:0]   spectrum_store [MEM_DEPTH];

  logic                       req_take;
  logic                       out_free;
  logic [MAG_W-1:0]           factor;
  logic [VALUE_W+MAG_W-1:0]   prod;
  logic                       k_in_range;
  logic                       k_stored;

  assign req_stall = rst || !ctl.take;
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign k_in_range = CW'(k) < BINS_C;
  assign k_stored   = CW'(k) < DEPTH_C;
  assign factor     = rd_stored ? rd_data : '0;
  assign prod       = {{MAG_W{1'b0}}, acc} * {{VALUE_W{1'b0}}, factor};

  // Microcode fetch and branch
  always_comb begin
    ctl = ucode_rom(step);
    unique case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_QUERY:    cond_true = req_take && (req.mode == MODE_QUERY);
      COND_LAST:     cond_true = (h == LAST_H);
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b1;
    endcase
    step_next = cond_true ? ctl.target : ctl.fall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // Spectrum RAM: write port in WAIT, registered read port in PRIME/LOOP
  always_ff @(posedge clk) begin
    if (req_take && req.mode == MODE_WRITE && CW'(req.bin_index) < BINS_C) begin
      spectrum_store[req.bin_index[AW-1:0]] <= req.magnitude;
    end
    if (ctl.issue_rd && k_stored) begin
      rd_data <= spectrum_store[k[AW-1:0]];
    end
  end

  // Product datapath
  always_ff @(posedge clk) begin
    if (req_take && req.mode == MODE_QUERY) begin
      j    <= req.bin_index;
      k    <= KW'(req.bin_index);
      h    <= HW'(1);
      acc  <= VALUE_W'(1);
      over <= 1'b0;
      zero <= !(CW'(req.bin_index) < BINS_C);
    end else begin
      if (ctl.issue_rd) begin
        rd_in_range <= k_in_range;
        rd_stored   <= k_stored;
        k           <= k + KW'(j);
      end
      if (ctl.mul) begin
        h <= h + HW'(1);
        if (rd_in_range) begin
          if (factor == '0) begin
            zero <= 1'b1;
          end else if (!over && !zero) begin
            if (|prod[VALUE_W+MAG_W-1:VALUE_W]) begin
              over <= 1'b1;
            end else begin
              acc <= prod[VALUE_W-1:0];
            end
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      rsp.bin_echo <= j;
      if (zero) begin
        rsp.hps_value <= '0;
        rsp.saturated <= 1'b0;
      end else if (over) begin
        rsp.hps_value <= '1;
        rsp.saturated <= 1'b1;
      end else begin
        rsp.hps_value <= acc;
        rsp.saturated <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_query_primes, req_take && req.mode == MODE_QUERY, step == STEP_PRIME,
               "accepted query did not start the read sequence")
  `ASSERT_NEXT(a_emit_loads, step == STEP_EMIT && out_free, rsp_valid,
               "result not loaded when the register was free")
  `ASSERT_IMPL(a_sat_all_ones, rsp_valid && rsp.saturated, rsp.hps_value == '1,
               "saturated result without all-ones value")
  `ASSERT_IMPL(a_h_bound, step == STEP_LOOP, h <= LAST_H && h != '0,
               "harmonic counter out of range in loop")

endmodule
